### sv/gpme_pkg.sv
// Shared types and constants for the GF(2) parity matrix engine.
`default_nettype none

package gpme_pkg;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_IDENT  = 3'd1,
		CMD_SET    = 3'd2,
		CMD_XOR    = 3'd3,
		CMD_REMOVE = 3'd4,
		CMD_QUERY  = 3'd5
	} cmd_t;

	// configuration register indexes
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_INIT_COLS = 1'b1;

	localparam logic [4:0] ROW_COUNT_RST = 5'd16;
	localparam logic [6:0] INIT_COLS_RST = 7'd64;

	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] row_index;
		logic [5:0] col_index;
		logic       bit_value;
		logic [3:0] control_row;
		logic [3:0] target_row;
	} item_t;

	typedef struct packed {
		logic [15:0] column_bits;
		logic [4:0]  column_ones;
		logic [3:0]  sole_row;
		logic        sole_found;
		logic        is_identity;
		logic [6:0]  cols_now;
		logic        index_error;
	} result_t;

	// what the update stage hands to the report stage
	typedef struct packed {
		logic       valid;
		logic [5:0] col;
		logic       err;
	} upd_t;

endpackage

`default_nettype wire

### sv/gpme_update.sv
// Matrix storage and the per-command row/column update logic.
`default_nettype none

module gpme_update
	import gpme_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire item_t               item_s1,
	input  wire logic [4:0]          rows_used,
	input  wire logic [6:0]          init_cols,
	output logic [MAX_COLS-1:0]      matrix_q [MAX_ROWS],
	output logic [6:0]               col_total_q,
	output upd_t                     upd_s2
);

	localparam logic [MAX_COLS-1:0] ONE_W = MAX_COLS'(1);
	localparam logic [6:0] COL_RST = 7'(MAX_COLS);

	logic [MAX_COLS-1:0] matrix_d [MAX_ROWS];
	logic [6:0]          col_total_d;
	logic                err;
	logic [MAX_COLS-1:0] tgt_word;
	logic [MAX_COLS-1:0] col_oh;
	logic [MAX_COLS-1:0] lo_mask;
	logic [6:0]          n7;
	logic [6:0]          col7;
	logic [6:0]          row7;
	logic [6:0]          ctl7;
	logic [6:0]          tgt7;

	always_comb begin
		n7   = {2'b00, rows_used};
		col7 = {1'b0, item_s1.col_index};
		row7 = {3'b000, item_s1.row_index};
		ctl7 = {3'b000, item_s1.control_row};
		tgt7 = {3'b000, item_s1.target_row};

		tgt_word = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (7'(r) == tgt7) begin
				tgt_word = tgt_word | matrix_q[r];
			end
		end
		for (int c = 0; c < MAX_COLS; c++) begin
			col_oh[c]  = (7'(c) == col7);
			lo_mask[c] = (7'(c) < col7);
		end

		matrix_d    = matrix_q;
		col_total_d = col_total_q;
		err         = 1'b0;

		case (item_s1.cmd)
			CMD_CLEAR: begin
				for (int r = 0; r < MAX_ROWS; r++) begin
					matrix_d[r] = '0;
				end
				col_total_d = init_cols;
			end
			CMD_IDENT: begin
				if (n7 > 7'(MAX_COLS)) begin
					err = 1'b1;
				end else begin
					for (int r = 0; r < MAX_ROWS; r++) begin
						matrix_d[r] = (7'(r) < n7) ? (ONE_W << r) : '0;
					end
					col_total_d = n7;
				end
			end
			CMD_SET: begin
				if (row7 >= n7 || col7 >= col_total_q) begin
					err = 1'b1;
				end else begin
					for (int r = 0; r < MAX_ROWS; r++) begin
						if (7'(r) == row7) begin
							matrix_d[r] = item_s1.bit_value ? (matrix_q[r] | col_oh)
								: (matrix_q[r] & ~col_oh);
						end
					end
				end
			end
			CMD_XOR: begin
				if (ctl7 >= n7 || tgt7 >= n7) begin
					err = 1'b1;
				end else if (ctl7 != tgt7) begin
					for (int r = 0; r < MAX_ROWS; r++) begin
						if (7'(r) == ctl7) begin
							matrix_d[r] = matrix_q[r] ^ tgt_word;
						end
					end
				end
			end
			CMD_REMOVE: begin
				if (col7 >= col_total_q) begin
					err = 1'b1;
				end else begin
					// bits above the count are zero, so the shift leaves the top clean
					for (int r = 0; r < MAX_ROWS; r++) begin
						matrix_d[r] = (matrix_q[r] & lo_mask) | ((matrix_q[r] >> 1) & ~lo_mask);
					end
					col_total_d = col_total_q - 7'd1;
				end
			end
			default: begin
				err = (col7 >= col_total_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++) begin
				matrix_q[r] <= '0;
			end
			col_total_q <= COL_RST;
			upd_s2      <= '0;
		end else begin
			if (valid_s1) begin
				matrix_q    <= matrix_d;
				col_total_q <= col_total_d;
			end
			upd_s2.valid <= valid_s1;
			upd_s2.col   <= item_s1.col_index;
			upd_s2.err   <= err;
		end
	end

endmodule

`default_nettype wire

### sv/gpme_report.sv
// Column report: bits, weight, sole row, identity flag, result register.
`default_nettype none

module gpme_report
	import gpme_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire upd_t                upd_s2,
	input  wire logic [MAX_COLS-1:0] matrix_q [MAX_ROWS],
	input  wire logic [6:0]          col_total_q,
	input  wire logic [4:0]          rows_used,
	output result_t                  result_q,
	output logic                     done_q
);

	localparam logic [MAX_COLS-1:0] ONE_W = MAX_COLS'(1);

	logic [MAX_COLS-1:0] col_oh;
	logic [MAX_ROWS-1:0] hits;
	logic [4:0]          ones;
	logic [3:0]          sole;
	logic                id_ok;
	logic [6:0]          n7;
	logic [6:0]          col7;
	logic                col_in;
	result_t             res_d;

	always_comb begin
		n7     = {2'b00, rows_used};
		col7   = {1'b0, upd_s2.col};
		col_in = (col7 < col_total_q);
		for (int c = 0; c < MAX_COLS; c++) begin
			col_oh[c] = (7'(c) == col7);
		end

		ones  = '0;
		sole  = '0;
		id_ok = (n7 == col_total_q);
		for (int r = 0; r < MAX_ROWS; r++) begin
			hits[r] = col_in && (7'(r) < n7) && (|(matrix_q[r] & col_oh));
			if (hits[r]) begin
				ones = ones + 5'd1;
				sole = 4'(r);
			end
			if ((7'(r) < n7) && (matrix_q[r] != (ONE_W << r))) begin
				id_ok = 1'b0;
			end
		end

		res_d.column_bits = 16'(hits);
		res_d.column_ones = ones;
		res_d.sole_found  = (ones == 5'd1);
		res_d.sole_row    = res_d.sole_found ? sole : 4'd0;
		res_d.is_identity = id_ok;
		res_d.cols_now    = col_total_q;
		res_d.index_error = upd_s2.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= upd_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s2.valid) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire

### sv/gf2_parity_matrix_engine_top.sv
// Top level of the GF(2) parity matrix engine.
//
// A bit matrix of up to MAX_ROWS rows by MAX_COLS columns held in flops.
// Command channel: a word on item is taken at a rising edge with start high
// and busy low. Every command (clear, identity, set bit, row xor, remove
// column, query) returns one word on result, marked by done for exactly one
// cycle; the receiver must take it then.
// Pipeline: input register, matrix update into the row flops, column report
// into the result register; done rises as the result word is written.
// Throughput: one command per cycle while busy is low; each command's matrix
// write lands before the next one reads the rows, so back-to-back commands
// chain.
// Configuration: cfg_we with cfg_index / cfg_wdata writes row_count (index 0)
// or initial_col_count (index 1) at the clock edge; write only while idle.
// Reset: the matrix clears, the column count becomes MAX_COLS, row_count is
// 16 and initial_col_count 64; busy stays high for the first cycle after
// reset is released and is low from then on.
`default_nettype none

module gf2_parity_matrix_engine_top
	import gpme_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire item_t      item,
	output logic            done,
	output result_t         result,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_wdata
);

	logic                busy_q;
	logic                valid_s1;
	item_t               item_s1;
	logic [4:0]          row_count_q;
	logic [6:0]          init_cols_q;
	logic [4:0]          rows_used;
	logic [6:0]          init_cols;
	logic [MAX_COLS-1:0] matrix_q [MAX_ROWS];
	logic [6:0]          col_total_q;
	upd_t                upd_s2;

	assign busy = busy_q;

	always_comb begin
		if (row_count_q == 5'd0) begin
			rows_used = 5'd1;
		end else if ({2'b00, row_count_q} > 7'(MAX_ROWS)) begin
			rows_used = 5'(MAX_ROWS);
		end else begin
			rows_used = row_count_q;
		end
		init_cols = (init_cols_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : init_cols_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			valid_s1    <= 1'b0;
			row_count_q <= ROW_COUNT_RST;
			init_cols_q <= INIT_COLS_RST;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= start && !busy_q;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_COUNT: row_count_q <= cfg_wdata[4:0];
					REG_INIT_COLS: init_cols_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			item_s1 <= item;
		end
	end

	gpme_update #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.rows_used  (rows_used),
		.init_cols  (init_cols),
		.matrix_q   (matrix_q),
		.col_total_q(col_total_q),
		.upd_s2     (upd_s2)
	);

	gpme_report #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_s2     (upd_s2),
		.matrix_q   (matrix_q),
		.col_total_q(col_total_q),
		.rows_used  (rows_used),
		.result_q   (result),
		.done_q     (done)
	);

endmodule

`default_nettype wire

### sv/gpme_checker.sv
// Port-level checks for the GF(2) parity matrix engine, bound to the top level.
`default_nettype none

module gpme_checker
	import gpme_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);

	// one word out for every word in, fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 3))
		else $error("done does not follow an accepted command by three cycles");

	a_sole: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.sole_found == (result.column_ones == 5'd1)))
		else $error("sole_found disagrees with column weight");

	a_sole_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.sole_found |-> (result.sole_row == 4'd0))
		else $error("sole_row nonzero without a sole one");

	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones(result.column_bits) <= 32'(result.column_ones)))
		else $error("column_bits has more ones than column_ones");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.cols_now == 7'd0) |-> (result.column_ones == 5'd0))
		else $error("column reported in a matrix with no columns");

endmodule

bind gf2_parity_matrix_engine_top gpme_checker u_chk (.*);

`default_nettype wire

### bench/gf2_parity_matrix_engine_checker.sv
// Checker for the GF(2) parity matrix engine: predicts each result word and compares it.
`timescale 1ns / 100ps

module gf2_parity_matrix_engine_checker
	import gpme_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  item_t      item,
	input  logic       done,
	input  result_t    result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_wdata,
	input  logic       run_done,
	output int         words_in_flight,
	output int         mismatch_count
);
	localparam int PRINT_LIMIT = 40;

	logic [63:0] mat_rows [MAX_ROWS];
	int unsigned col_total;
	logic [4:0]  row_count_reg;
	logic [6:0]  init_cols_reg;
	result_t     expected_words [$];
	bit          leftover_checked;

	function automatic int unsigned rows_in_use();
		if (row_count_reg == 0) return 1;
		if (row_count_reg > MAX_ROWS) return MAX_ROWS;
		return row_count_reg;
	endfunction

	function automatic int unsigned init_cols_in_use();
		if (init_cols_reg > MAX_COLS) return MAX_COLS;
		return init_cols_reg;
	endfunction

	function automatic logic [63:0] low_bits(int unsigned n);
		if (n >= 64) return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic bit square_identity();
		int unsigned n;
		n = rows_in_use();
		if (n != col_total) return 1'b0;
		for (int unsigned r = 0; r < n; r++)
			if (mat_rows[r] != (64'd1 << r)) return 1'b0;
		return 1'b1;
	endfunction

	// applies one command to the matrix and builds the word it returns
	task automatic run_command(input item_t w, output result_t res);
		int unsigned n, col, ones, sole;
		logic        err, found;
		logic [15:0] bits;
		logic [63:0] v, lo, hi;
		n = rows_in_use();
		col = w.col_index;
		err = 1'b0;
		found = 1'b0;
		bits = '0;
		ones = 0;
		sole = 0;
		case (w.cmd)
			CMD_CLEAR: begin
				for (int r = 0; r < MAX_ROWS; r++) mat_rows[r] = '0;
				col_total = init_cols_in_use();
			end
			CMD_IDENT: begin
				if (n > MAX_COLS) begin
					err = 1'b1;
				end else begin
					for (int unsigned r = 0; r < MAX_ROWS; r++)
						mat_rows[r] = (r < n) ? (64'd1 << r) : 64'd0;
					col_total = n;
				end
			end
			CMD_SET: begin
				if (w.row_index >= n || col >= col_total) err = 1'b1;
				else mat_rows[w.row_index][col] = w.bit_value;
			end
			CMD_XOR: begin
				if (w.control_row >= n || w.target_row >= n) err = 1'b1;
				else if (w.control_row != w.target_row)
					mat_rows[w.control_row] ^= mat_rows[w.target_row];
			end
			CMD_REMOVE: begin
				if (col >= col_total) begin
					err = 1'b1;
				end else begin
					// columns above col slide down by one
					for (int r = 0; r < MAX_ROWS; r++) begin
						v = mat_rows[r];
						lo = v & low_bits(col);
						hi = (col + 1 < 64) ? ((v >> (col + 1)) << col) : 64'd0;
						mat_rows[r] = (lo | hi) & low_bits(col_total - 1);
					end
					col_total--;
				end
			end
			default: begin
				// query, and the spare codes behave the same
				if (col >= col_total) err = 1'b1;
			end
		endcase
		if (col < col_total) begin
			for (int unsigned r = 0; r < n; r++) begin
				if (mat_rows[r][col]) begin
					bits[r] = 1'b1;
					ones++;
					sole = r;
				end
			end
			if (ones == 1) found = 1'b1;
			else sole = 0;
		end
		res.column_bits = bits;
		res.column_ones = 5'(ones);
		res.sole_row    = 4'(sole);
		res.sole_found  = found;
		res.is_identity = square_identity();
		res.cols_now    = 7'(col_total);
		res.index_error = err;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++) mat_rows[r] = '0;
			row_count_reg = ROW_COUNT_RST;
			init_cols_reg = INIT_COLS_RST;
			col_total = init_cols_in_use();
			expected_words.delete();
			leftover_checked = 1'b0;
			mismatch_count = 0;
			words_in_flight <= 0;
		end else begin
			// retire before accepting, a word may leave and enter on one edge
			if (done) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with none expected", result, '0);
				end else begin
					want = expected_words.pop_front();
					if (result.column_bits !== want.column_bits)
						report_mismatch("column_bits", result.column_bits, want.column_bits);
					if (result.column_ones !== want.column_ones)
						report_mismatch("column_ones", result.column_ones, want.column_ones);
					if (result.sole_row !== want.sole_row)
						report_mismatch("sole_row", result.sole_row, want.sole_row);
					if (result.sole_found !== want.sole_found)
						report_mismatch("sole_found", result.sole_found, want.sole_found);
					if (result.is_identity !== want.is_identity)
						report_mismatch("is_identity", result.is_identity, want.is_identity);
					if (result.cols_now !== want.cols_now)
						report_mismatch("cols_now", result.cols_now, want.cols_now);
					if (result.index_error !== want.index_error)
						report_mismatch("index_error", result.index_error, want.index_error);
				end
			end
			if (start && !busy) begin
				run_command(item, want);
				expected_words.push_back(want);
			end
			if (cfg_we) begin
				if (cfg_index == REG_ROW_COUNT) row_count_reg = cfg_wdata[4:0];
				else init_cols_reg = cfg_wdata;
			end
			if (run_done && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (expected_words.size() != 0)
					report_mismatch("result words never returned", expected_words.size(), 0);
			end
			words_in_flight <= expected_words.size();
		end
	end

endmodule

### bench/tb_gf2_parity_matrix_engine_top.sv
// Testbench top for the GF(2) parity matrix engine: clock, reset, command stimulus, verdict.
`timescale 1ns / 100ps

module tb_gf2_parity_matrix_engine_top
	import gpme_pkg::*;
();

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 100;
	localparam int STALL_LIMIT     = 500;
	localparam int ITEM_BITS       = $bits(item_t);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item_word = '0;
	logic        done;
	result_t     result_word;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_ROW_COUNT;
	logic [6:0]  cfg_wdata = '0;
	logic        run_done = 1'b0;
	int          words_in_flight;
	int          mismatch_count;
	int unsigned stall_cycles = 0;
	int unsigned rows_active = ROW_COUNT_RST;
	logic [6:0]  cols_seen = INIT_COLS_RST;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	gf2_parity_matrix_engine_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item_word),
		.done     (done),
		.result   (result_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	gf2_parity_matrix_engine_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item_word),
		.done           (done),
		.result         (result_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.run_done       (run_done),
		.words_in_flight(words_in_flight),
		.mismatch_count (mismatch_count)
	);

	// column count as last reported, used to steer indices into range
	always @(posedge clk) begin
		if (done) cols_seen <= result_word.cols_now;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_gf2_parity_matrix_engine_top: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic item_t make_word(cmd_t op, int row = 0, int col = 0, int bitv = 0,
			int ctl = 0, int tgt = 0);
		item_t w;
		w.cmd         = op;
		w.row_index   = 4'(row);
		w.col_index   = 6'(col);
		w.bit_value   = 1'(bitv);
		w.control_row = 4'(ctl);
		w.target_row  = 4'(tgt);
		return w;
	endfunction

	function automatic item_t random_word();
		logic [ITEM_BITS-1:0] raw;
		item_t       w;
		int unsigned pick;
		raw = ITEM_BITS'($urandom);
		w = item_t'(raw);
		pick = $urandom_range(0, 99);
		if (pick < 4) w.cmd = CMD_CLEAR;
		else if (pick < 10) w.cmd = CMD_IDENT;
		else if (pick < 45) w.cmd = CMD_SET;
		else if (pick < 70) w.cmd = CMD_XOR;
		else if (pick < 80) w.cmd = CMD_REMOVE;
		else if (pick < 95) w.cmd = CMD_QUERY;
		// else the raw code stands, spare codes included
		if ($urandom_range(0, 9) < 8) begin
			w.row_index   = 4'($urandom_range(0, rows_active - 1));
			w.control_row = 4'($urandom_range(0, rows_active - 1));
			w.target_row  = ($urandom_range(0, 9) == 0) ? w.control_row
				: 4'($urandom_range(0, rows_active - 1));
		end
		pick = $urandom_range(0, 9);
		if (pick < 6 && cols_seen != 0) w.col_index = 6'($urandom_range(0, cols_seen - 1));
		else if (pick < 8) w.col_index = 6'($urandom_range(0, 15));
		return w;
	endfunction

	// holds start until the word is taken; call right after the clock rises
	task automatic send_word(input item_t w);
		start <= 1'b1;
		item_word <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_start(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// registers change only with the engine drained
	task automatic write_config(input logic [6:0] rows_val, input logic [6:0] cols_val);
		start <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_wdata <= rows_val;
		@(posedge clk);
		cfg_index <= REG_INIT_COLS;
		cfg_wdata <= cols_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (rows_val[4:0] == 0) rows_active = 1;
		else if (rows_val[4:0] > 16) rows_active = 16;
		else rows_active = rows_val[4:0];
	endtask

	initial begin
		logic [6:0]  rows_val, cols_val;
		bit          quiet;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 16 rows, 64 columns
		send_word(make_word(CMD_QUERY));
		send_word(make_word(CMD_IDENT, 0, 15));
		send_word(make_word(CMD_QUERY, 0, 63));
		send_word(make_word(CMD_SET, 15, 63, 1));
		send_word(make_word(CMD_SET, 3, 5, 1));
		send_word(make_word(CMD_SET, 3, 5, 0));
		send_word(make_word(CMD_XOR, 0, 2, 0, 2, 2));
		send_word(make_word(CMD_XOR, 0, 15, 0, 0, 15));
		send_word(make_word(CMD_REMOVE, 0, 0));
		send_word(make_word(CMD_REMOVE, 0, 14));
		send_word(make_word(CMD_REMOVE, 0, 63));
		send_word(make_word(cmd_t'(CMD_SPARE_A), 0, 3));
		send_word(make_word(cmd_t'(CMD_SPARE_B), 15, 63, 1, 15, 15));
		send_word(make_word(CMD_CLEAR, 0, 63));
		send_word(make_word(CMD_SET, 15, 63, 1));
		send_word(make_word(CMD_XOR, 0, 63, 0, 0, 15));
		send_word(make_word(CMD_XOR, 0, 63, 0, 15, 0));
		send_word(make_word(CMD_SET, 7, 0, 1));

		// one row in use hides row 7; raising the count shows it again
		write_config(7'd1, 7'd127);
		send_word(make_word(CMD_QUERY, 0, 0));
		send_word(make_word(CMD_XOR, 0, 0, 0, 0, 7));
		write_config(7'd16, 7'd0);
		send_word(make_word(CMD_QUERY, 0, 0));
		send_word(make_word(CMD_CLEAR));
		send_word(make_word(CMD_REMOVE, 0, 0));
		send_word(make_word(CMD_QUERY, 0, 0));
		send_word(make_word(CMD_IDENT, 0, 15));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin rows_val = 7'd0;   cols_val = 7'd64;  end
				1: begin rows_val = 7'd1;   cols_val = 7'd127; end
				2: begin rows_val = 7'd127; cols_val = 7'd0;   end
				3: begin rows_val = 7'd16;  cols_val = 7'd64;  end
				default: begin
					rows_val = 7'($urandom_range(0, 127));
					cols_val = 7'($urandom_range(0, 127));
				end
			endcase
			write_config(rows_val, cols_val);
			quiet = (phase == 3) || (phase == RANDOM_PHASES - 1);
			send_word(make_word($urandom_range(0, 1) ? CMD_CLEAR : CMD_IDENT));
			for (int k = 1; k < WORDS_PER_PHASE; k++) begin
				if (!quiet && $urandom_range(0, 99) < 20) pause_start($urandom_range(1, 5));
				send_word(random_word());
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_gf2_parity_matrix_engine_top: PASS");
		end else begin
			$display("tb_gf2_parity_matrix_engine_top: FAIL");
		end
		$finish;
	end

endmodule
